### rtl/core/line_follow_dual_pid_speed_core_defines.svh
// Assertion macros shared by the line follower speed core
`ifndef LINE_FOLLOW_DUAL_PID_SPEED_CORE_DEFINES_SVH
`define LINE_FOLLOW_DUAL_PID_SPEED_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define LFDS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define LFDS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LFDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/lfds_pkg.sv
// Types and constants of the line follower speed core
package lfds_pkg;

	localparam int SENSOR_W = 12;
	localparam int COUNT_W = 32;
	localparam int GAIN_W = 24;
	localparam int SPEED_W = 16;
	localparam int DUTY_W = 17;
	localparam int ERR_W = 32;
	localparam int INTEG_W = 48;

	localparam int TICKS_PER_SECOND = 100;
	localparam int LINE_THRESHOLD = 2048;
	localparam int OVERFLOW_DELTA = 50000;
	localparam int DUTY_FULL = 65536;

	// weighted line error spans +/-6*4095
	localparam int LINE_W = 16;
	// base +/- offset spans -65535..131070
	localparam int TGT_W = SPEED_W + 2;
	localparam int TICK_W = $clog2(TICKS_PER_SECOND + 1) + 1;

	// registers from lane input to lane duty output
	localparam int LANE_LAT = 5;
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

	localparam int REG_COUNT = 8;
	localparam int DATA_W = 32;
	localparam int ADDR_W = $clog2(REG_COUNT * 4);

	localparam logic signed [GAIN_W-1:0] KP_RESET = 24'sd6554;
	localparam logic signed [GAIN_W-1:0] KI_RESET = 24'sd66;
	localparam logic signed [GAIN_W-1:0] KD_RESET = 24'sd655360;
	localparam logic [SPEED_W-1:0] BASE_RESET = 16'd3500;
	localparam logic [SPEED_W-1:0] OFFSET_RESET = 16'd500;

	typedef enum logic [1:0] {
		STEER_STRAIGHT = 2'd0,
		STEER_RIGHT    = 2'd1,
		STEER_LEFT     = 2'd2
	} steer_t;

	typedef enum logic [2:0] {
		REG_KP_LEFT,
		REG_KI_LEFT,
		REG_KD_LEFT,
		REG_KP_RIGHT,
		REG_KI_RIGHT,
		REG_KD_RIGHT,
		REG_BASE_SPEED,
		REG_STEER_OFFSET
	} reg_idx_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
	} gains_t;

	typedef struct packed {
		logic                      vld;
		logic signed [TGT_W-1:0]   target;
		logic signed [COUNT_W-1:0] delta;
	} lane_in_t;

	typedef struct packed {
		logic   vld;
		logic   encoder_reset;
		steer_t steer;
	} side_t;

	typedef struct packed {
		logic [DUTY_W-1:0] left_duty;
		logic [DUTY_W-1:0] right_duty;
		logic              encoder_reset;
		steer_t            steer;
	} result_t;

endpackage

### rtl/core/lfds_ifs.sv
// Valid/ready channel interfaces for sensor beats and duty beats
interface lfds_sense_if import lfds_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [SENSOR_W-1:0]       sensor_1;
	logic [SENSOR_W-1:0]       sensor_2;
	logic [SENSOR_W-1:0]       sensor_3;
	logic [SENSOR_W-1:0]       sensor_4;
	logic [SENSOR_W-1:0]       sensor_5;
	logic [SENSOR_W-1:0]       sensor_6;
	logic signed [COUNT_W-1:0] left_count;
	logic signed [COUNT_W-1:0] right_count;

	modport source (
		output valid, sensor_1, sensor_2, sensor_3, sensor_4, sensor_5, sensor_6,
			left_count, right_count,
		input ready
	);
	modport sink (
		input valid, sensor_1, sensor_2, sensor_3, sensor_4, sensor_5, sensor_6,
			left_count, right_count,
		output ready
	);
endinterface

interface lfds_drive_if import lfds_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] left_duty;
	logic [DUTY_W-1:0] right_duty;
	logic              encoder_reset;
	logic [1:0]        steer_state;

	modport source (
		output valid, left_duty, right_duty, encoder_reset, steer_state,
		input ready
	);
	modport sink (
		input valid, left_duty, right_duty, encoder_reset, steer_state,
		output ready
	);
endinterface

### rtl/core/lfds_front.sv
// Front stage: line error, steering targets, encoder deltas and overflow
module lfds_front import lfds_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [SENSOR_W-1:0]       sensor_1,
	input  logic [SENSOR_W-1:0]       sensor_2,
	input  logic [SENSOR_W-1:0]       sensor_3,
	input  logic [SENSOR_W-1:0]       sensor_4,
	input  logic [SENSOR_W-1:0]       sensor_5,
	input  logic [SENSOR_W-1:0]       sensor_6,
	input  logic signed [COUNT_W-1:0] left_count,
	input  logic signed [COUNT_W-1:0] right_count,
	input  logic [SPEED_W-1:0]        base_speed,
	input  logic [SPEED_W-1:0]        steer_offset,
	output lane_in_t                  left_s1,
	output lane_in_t                  right_s1,
	output side_t                     side_s1
);

	localparam logic signed [LINE_W-1:0] THR = LINE_W'(LINE_THRESHOLD);
	localparam logic signed [COUNT_W-1:0] OVF = COUNT_W'(OVERFLOW_DELTA);

	logic signed [LINE_W-1:0]  w1, w2, w3, w4, w5, w6;
	logic signed [LINE_W-1:0]  pos, neg, line;
	logic signed [TGT_W-1:0]   bs, os, t_up, t_dn, tgt_l, tgt_r;
	steer_t                    steer;
	logic signed [COUNT_W-1:0] dl, dr;
	logic                      ovf;

	logic signed [COUNT_W-1:0] last_left_q, last_right_q;
	logic                      vld_s1;
	logic signed [TGT_W-1:0]   tgt_l_s1, tgt_r_s1;
	logic signed [COUNT_W-1:0] dl_s1, dr_s1;
	logic                      rst_s1;
	steer_t                    steer_s1;

	assign w1 = LINE_W'($signed({1'b0, sensor_1}));
	assign w2 = LINE_W'($signed({1'b0, sensor_2}));
	assign w3 = LINE_W'($signed({1'b0, sensor_3}));
	assign w4 = LINE_W'($signed({1'b0, sensor_4}));
	assign w5 = LINE_W'($signed({1'b0, sensor_5}));
	assign w6 = LINE_W'($signed({1'b0, sensor_6}));

	// both halves stay within +/-24570, so no intermediate overflow
	assign pos  = (w1 <<< 1) + w1 + (w2 <<< 1) + w3;
	assign neg  = w4 + (w5 <<< 1) + (w6 <<< 1) + w6;
	assign line = pos - neg;

	assign bs   = TGT_W'($signed({1'b0, base_speed}));
	assign os   = TGT_W'($signed({1'b0, steer_offset}));
	assign t_up = bs + os;
	assign t_dn = bs - os;

	always_comb begin
		steer = STEER_STRAIGHT;
		tgt_l = bs;
		tgt_r = bs;
		if (line > THR) begin
			steer = STEER_RIGHT;
			tgt_l = t_dn;
			tgt_r = t_up;
		end else if (line < -THR) begin
			steer = STEER_LEFT;
			tgt_l = t_up;
			tgt_r = t_dn;
		end
	end

	// wrapping 32-bit difference against the last count
	assign dl  = left_count - last_left_q;
	assign dr  = right_count - last_right_q;
	assign ovf = (dl > OVF) || (dr > OVF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			last_left_q  <= '0;
			last_right_q <= '0;
		end else begin
			vld_s1 <= accept;
			if (accept) begin
				last_left_q  <= ovf ? '0 : left_count;
				last_right_q <= ovf ? '0 : right_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_l_s1 <= tgt_l;
			tgt_r_s1 <= tgt_r;
			dl_s1    <= dl;
			dr_s1    <= dr;
			rst_s1   <= ovf;
			steer_s1 <= steer;
		end
	end

	assign left_s1  = '{vld: vld_s1, target: tgt_l_s1, delta: dl_s1};
	assign right_s1 = '{vld: vld_s1, target: tgt_r_s1, delta: dr_s1};
	assign side_s1  = '{vld: vld_s1, encoder_reset: rst_s1, steer: steer_s1};

endmodule

### rtl/core/lfds_lane.sv
// One wheel lane: speed error, integral and difference state, PID products, duty clamp
module lfds_lane import lfds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  lane_in_t          din,
	input  gains_t            gains,
	output logic              vld_s6,
	output logic [DUTY_W-1:0] duty_s6
);

	localparam int PROD_W  = COUNT_W + TICK_W;
	localparam int EFULL_W = PROD_W + 1;
	localparam int DIFF_W  = ERR_W + 1;
	localparam int PKP_W   = GAIN_W + ERR_W;
	localparam int PKD_W   = GAIN_W + DIFF_W;
	localparam int HALF_W  = INTEG_W / 2;
	localparam int PIH_W   = GAIN_W + INTEG_W - HALF_W;
	localparam int PIL_W   = GAIN_W + HALF_W + 1;
	localparam int PA_W    = PKD_W + 1;
	localparam int SUM_W   = GAIN_W + INTEG_W + 2;
	localparam logic signed [TICK_W-1:0] TICKS = TICK_W'(TICKS_PER_SECOND);

	// stage 1: measured speed and saturated speed error
	logic signed [PROD_W-1:0]  spd;
	logic signed [EFULL_W-1:0] err_full;
	logic signed [ERR_W-1:0]   err_sat;

	// stage 2: integral and difference
	logic                      vld_s2;
	logic signed [ERR_W-1:0]   err_s2;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]   prev_q;
	logic signed [INTEG_W:0]   integ_sum;
	logic signed [INTEG_W-1:0] integ_next;
	logic signed [DIFF_W-1:0]  diff;

	// stage 3: products
	logic                      vld_s3;
	logic signed [ERR_W-1:0]   err_s3;
	logic signed [INTEG_W-1:0] integ_s3;
	logic signed [DIFF_W-1:0]  diff_s3;
	logic signed [PKP_W-1:0]   p_kp;
	logic signed [PKD_W-1:0]   p_kd;
	logic signed [PIH_W-1:0]   p_ih;
	logic signed [PIL_W-1:0]   p_il;

	// stage 4: partial sums
	logic                      vld_s4;
	logic signed [PKP_W-1:0]   p_kp_s4;
	logic signed [PKD_W-1:0]   p_kd_s4;
	logic signed [PIH_W-1:0]   p_ih_s4;
	logic signed [PIL_W-1:0]   p_il_s4;
	logic signed [PA_W-1:0]    pa;
	logic signed [SUM_W-1:0]   pi;

	// stage 5: final sum and clamp
	logic                      vld_s5;
	logic signed [PA_W-1:0]    pa_s5;
	logic signed [SUM_W-1:0]   pi_s5;
	logic signed [SUM_W-1:0]   total;
	logic [DUTY_W-1:0]         duty;

	assign spd      = din.delta * TICKS;
	assign err_full = EFULL_W'(din.target) - EFULL_W'(spd);

	always_comb begin
		if (err_full[EFULL_W-1:ERR_W-1] == {(EFULL_W-ERR_W+1){err_full[EFULL_W-1]}}) begin
			err_sat = err_full[ERR_W-1:0];
		end else if (err_full[EFULL_W-1]) begin
			err_sat = {1'b1, {(ERR_W-1){1'b0}}};
		end else begin
			err_sat = {1'b0, {(ERR_W-1){1'b1}}};
		end
	end

	assign integ_sum = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(err_s2);
	assign diff      = DIFF_W'(err_s2) - DIFF_W'(prev_q);

	always_comb begin
		if (integ_sum[INTEG_W] == integ_sum[INTEG_W-1]) begin
			integ_next = integ_sum[INTEG_W-1:0];
		end else if (integ_sum[INTEG_W]) begin
			integ_next = {1'b1, {(INTEG_W-1){1'b0}}};
		end else begin
			integ_next = {1'b0, {(INTEG_W-1){1'b1}}};
		end
	end

	// ki*I is split into two 24-bit halves of the integral.
	// Kept exact rather than saturated: once it passes 2^62 the other
	// terms cannot change the sign, so the clamped duty is the same.
	assign p_kp = gains.kp * err_s3;
	assign p_kd = gains.kd * diff_s3;
	assign p_ih = gains.ki * $signed(integ_s3[INTEG_W-1:HALF_W]);
	assign p_il = gains.ki * $signed({1'b0, integ_s3[HALF_W-1:0]});

	assign pa = PA_W'(p_kp_s4) + PA_W'(p_kd_s4);
	assign pi = (SUM_W'(p_ih_s4) <<< HALF_W) + SUM_W'(p_il_s4);

	assign total = SUM_W'(pa_s5) + pi_s5;

	always_comb begin
		if (total[SUM_W-1]) begin
			duty = '0;
		end else if (total > SUM_W'(DUTY_FULL)) begin
			duty = DUTY_W'(DUTY_FULL);
		end else begin
			duty = total[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			integ_q <= '0;
			prev_q  <= '0;
		end else begin
			vld_s2 <= din.vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			if (vld_s2) begin
				integ_q <= integ_next;
				prev_q  <= err_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		err_s2   <= err_sat;
		err_s3   <= err_s2;
		integ_s3 <= integ_next;
		diff_s3  <= diff;
		p_kp_s4  <= p_kp;
		p_kd_s4  <= p_kd;
		p_ih_s4  <= p_ih;
		p_il_s4  <= p_il;
		pa_s5    <= pa;
		pi_s5    <= pi;
		duty_s6  <= duty;
	end

endmodule

### rtl/core/lfds_merge.sv
// Merge of both lanes with the delayed steering info into the result queue
`include "line_follow_dual_pid_speed_core_defines.svh"

module lfds_merge import lfds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  side_t             side_s1,
	input  logic              left_vld,
	input  logic [DUTY_W-1:0] left_duty,
	input  logic              right_vld,
	input  logic [DUTY_W-1:0] right_duty,
	lfds_drive_if.source      drive,
	output logic              pop
);

	side_t             side_dly_q [LANE_LAT];
	result_t           fifo_mem [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              wr;
	result_t           rd_beat;

	// side info rides alongside the lane stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_LAT; i++) begin
				side_dly_q[i] <= '0;
			end
		end else begin
			side_dly_q[0] <= side_s1;
			for (int i = 1; i < LANE_LAT; i++) begin
				side_dly_q[i] <= side_dly_q[i-1];
			end
		end
	end

	assign wr  = left_vld;
	assign pop = drive.valid & drive.ready;

	always_ff @(posedge clk) begin
		if (wr) begin
			fifo_mem[wr_ptr_q] <= '{
				left_duty:     left_duty,
				right_duty:    right_duty,
				encoder_reset: side_dly_q[LANE_LAT-1].encoder_reset,
				steer:         side_dly_q[LANE_LAT-1].steer
			};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	assign rd_beat             = fifo_mem[rd_ptr_q];
	assign drive.valid         = (fill_q != '0);
	assign drive.left_duty     = rd_beat.left_duty;
	assign drive.right_duty    = rd_beat.right_duty;
	assign drive.encoder_reset = rd_beat.encoder_reset;
	assign drive.steer_state   = rd_beat.steer;

	`LFDS_ASSERT_ALWAYS(a_lanes_lockstep, (left_vld == right_vld) && (left_vld == side_dly_q[LANE_LAT-1].vld), "lane outputs out of step with side info")
	`LFDS_ASSERT_IMPLY(a_no_overrun, wr, fill_q < FILL_W'(FIFO_DEPTH), "result queue overrun")
	`LFDS_ASSERT_IMPLY(a_duty_range, wr, (left_duty <= DUTY_W'(DUTY_FULL)) && (right_duty <= DUTY_W'(DUTY_FULL)), "duty beyond full scale")
	`LFDS_ASSERT_NEXT(a_fill_drains, pop && !wr, fill_q == $past(fill_q) - 1'b1, "fill count off after a read")

endmodule

### rtl/core/line_follow_dual_pid_speed_core.sv
// Line follower dual PID speed core. Each sense beat (six line samples,
// two encoder counts) yields one drive beat (two duties, encoder reset
// request, steer state). One beat is accepted per cycle while the credit
// count is below eight: a front stage forms the line error and count deltas,
// two PID lanes run side by side, and a merge stage queues results in an
// 8-entry output queue. Sense ready is driven from a credit count over that
// queue, so at most eight beats are in flight or waiting; with drive ready
// held high the rate is one beat per cycle. Gains and speeds are written over
// the APB port (register i at byte address 4*i); the user must write them
// only while the core is idle, and the core itself does not enforce this.
module line_follow_dual_pid_speed_core import lfds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	lfds_sense_if.sink        sense,
	lfds_drive_if.source      drive
);

	logic signed [GAIN_W-1:0] kp_left_q, ki_left_q, kd_left_q;
	logic signed [GAIN_W-1:0] kp_right_q, ki_right_q, kd_right_q;
	logic [SPEED_W-1:0]       base_speed_q, steer_offset_q;
	reg_idx_t                 reg_idx;
	logic                     cfg_wr;

	logic [FILL_W-1:0]        credit_q;
	logic                     accept;
	logic                     pop;

	lane_in_t                 left_s1, right_s1;
	side_t                    side_s1;
	gains_t                   gains_left, gains_right;
	logic                     left_vld, right_vld;
	logic [DUTY_W-1:0]        left_duty, right_duty;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_left_q      <= KP_RESET;
			ki_left_q      <= KI_RESET;
			kd_left_q      <= KD_RESET;
			kp_right_q     <= KP_RESET;
			ki_right_q     <= KI_RESET;
			kd_right_q     <= KD_RESET;
			base_speed_q   <= BASE_RESET;
			steer_offset_q <= OFFSET_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_KP_LEFT:      kp_left_q      <= pwdata[GAIN_W-1:0];
				REG_KI_LEFT:      ki_left_q      <= pwdata[GAIN_W-1:0];
				REG_KD_LEFT:      kd_left_q      <= pwdata[GAIN_W-1:0];
				REG_KP_RIGHT:     kp_right_q     <= pwdata[GAIN_W-1:0];
				REG_KI_RIGHT:     ki_right_q     <= pwdata[GAIN_W-1:0];
				REG_KD_RIGHT:     kd_right_q     <= pwdata[GAIN_W-1:0];
				REG_BASE_SPEED:   base_speed_q   <= pwdata[SPEED_W-1:0];
				REG_STEER_OFFSET: steer_offset_q <= pwdata[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_KP_LEFT:      prdata = DATA_W'(kp_left_q);
			REG_KI_LEFT:      prdata = DATA_W'(ki_left_q);
			REG_KD_LEFT:      prdata = DATA_W'(kd_left_q);
			REG_KP_RIGHT:     prdata = DATA_W'(kp_right_q);
			REG_KI_RIGHT:     prdata = DATA_W'(ki_right_q);
			REG_KD_RIGHT:     prdata = DATA_W'(kd_right_q);
			REG_BASE_SPEED:   prdata = {{(DATA_W-SPEED_W){1'b0}}, base_speed_q};
			REG_STEER_OFFSET: prdata = {{(DATA_W-SPEED_W){1'b0}}, steer_offset_q};
			default:          prdata = '0;
		endcase
	end

	// credits cover lane stages plus queue, so the queue never overruns
	assign sense.ready = (credit_q < FILL_W'(FIFO_DEPTH));
	assign accept      = sense.valid & sense.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			case ({accept, pop})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	assign gains_left  = '{kp: kp_left_q, ki: ki_left_q, kd: kd_left_q};
	assign gains_right = '{kp: kp_right_q, ki: ki_right_q, kd: kd_right_q};

	lfds_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.sensor_1     (sense.sensor_1),
		.sensor_2     (sense.sensor_2),
		.sensor_3     (sense.sensor_3),
		.sensor_4     (sense.sensor_4),
		.sensor_5     (sense.sensor_5),
		.sensor_6     (sense.sensor_6),
		.left_count   (sense.left_count),
		.right_count  (sense.right_count),
		.base_speed   (base_speed_q),
		.steer_offset (steer_offset_q),
		.left_s1      (left_s1),
		.right_s1     (right_s1),
		.side_s1      (side_s1)
	);

	lfds_lane u_lane_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (left_s1),
		.gains   (gains_left),
		.vld_s6  (left_vld),
		.duty_s6 (left_duty)
	);

	lfds_lane u_lane_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (right_s1),
		.gains   (gains_right),
		.vld_s6  (right_vld),
		.duty_s6 (right_duty)
	);

	lfds_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.side_s1    (side_s1),
		.left_vld   (left_vld),
		.left_duty  (left_duty),
		.right_vld  (right_vld),
		.right_duty (right_duty),
		.drive      (drive),
		.pop        (pop)
	);

endmodule

### verif/tb_line_follow_dual_pid_speed_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the line follower dual PID speed core
module tb_line_follow_dual_pid_speed_core;
	import lfds_pkg::*;

	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 11;
	localparam int IDLE_PCT = 9;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int PRINT_CAP = 100;
	localparam int RANDOM_PHASES = 7;
	localparam int BEATS_PER_PHASE = 190;

	localparam longint ERR_HI = (longint'(1) <<< 31) - 1;
	localparam longint ERR_LO = -(longint'(1) <<< 31);
	localparam longint INTEG_HI = (longint'(1) <<< 47) - 1;
	localparam longint INTEG_LO = -(longint'(1) <<< 47);

	typedef logic [5:0][SENSOR_W-1:0] line_t;

	typedef struct packed {
		line_t               line;
		logic [COUNT_W-1:0]  lcount;
		logic [COUNT_W-1:0]  rcount;
	} tick_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	lfds_sense_if sense ();
	lfds_drive_if drive ();

	line_follow_dual_pid_speed_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.sense   (sense),
		.drive   (drive)
	);

	always #(CLK_HALF) clk = ~clk;

	// pending ticks and expected drive beats
	tick_t   tick_q [$];
	result_t duty_expect_q [$];

	// predictor copy of registers and block state
	logic [DATA_W-1:0]  reg_mirror [REG_COUNT];
	logic [COUNT_W-1:0] last_lcount = '0;
	logic [COUNT_W-1:0] last_rcount = '0;
	longint             integ_sum [2] = '{0, 0};
	longint             prev_err [2] = '{0, 0};

	// stimulus view of the counts the block holds
	logic [COUNT_W-1:0] enc_last_l = '0;
	logic [COUNT_W-1:0] enc_last_r = '0;

	bit calm = 1'b0;
	bit sense_fire = 1'b0;
	int err_count = 0;
	int cycle_count = 0;
	int ticks_in = 0;
	int beats_checked = 0;
	int n_right = 0, n_left = 0, n_clear = 0, n_zero = 0, n_full = 0;

	task automatic report_mismatch(string msg);
		err_count++;
		if (err_count <= PRINT_CAP)
			$display("MISMATCH @%0t beat %0d: %s", $time, beats_checked, msg);
	endtask

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < IDLE_PCT);
	endfunction

	function automatic logic [DUTY_W-1:0] wheel_pid(bit right, longint err);
		reg_idx_t            kp_i, ki_i, kd_i;
		logic signed [127:0] kp, ki, kd, acc;
		longint              isum;
		kp_i = right ? REG_KP_RIGHT : REG_KP_LEFT;
		ki_i = right ? REG_KI_RIGHT : REG_KI_LEFT;
		kd_i = right ? REG_KD_RIGHT : REG_KD_LEFT;
		kp = $signed(reg_mirror[kp_i][GAIN_W-1:0]);
		ki = $signed(reg_mirror[ki_i][GAIN_W-1:0]);
		kd = $signed(reg_mirror[kd_i][GAIN_W-1:0]);
		isum = integ_sum[right] + err;
		if (isum > INTEG_HI)
			isum = INTEG_HI;
		else if (isum < INTEG_LO)
			isum = INTEG_LO;
		integ_sum[right] = isum;
		// exact wide products: the duty clamp hides any product saturation
		acc = kp * err + ki * isum + kd * (err - prev_err[right]);
		prev_err[right] = err;
		if (acc < 0)
			return '0;
		if (acc > DUTY_FULL)
			return DUTY_W'(DUTY_FULL);
		return acc[DUTY_W-1:0];
	endfunction

	function automatic result_t drive_predict(tick_t t);
		result_t            r;
		int                 line_err;
		longint             base, off, lt, rt, el, er;
		logic [COUNT_W-1:0] dl, dr;
		line_err = 3 * int'(t.line[0]) + 2 * int'(t.line[1]) + int'(t.line[2])
			- int'(t.line[3]) - 2 * int'(t.line[4]) - 3 * int'(t.line[5]);
		base = longint'(reg_mirror[REG_BASE_SPEED][SPEED_W-1:0]);
		off = longint'(reg_mirror[REG_STEER_OFFSET][SPEED_W-1:0]);
		lt = base;
		rt = base;
		r.steer = STEER_STRAIGHT;
		if (line_err > LINE_THRESHOLD) begin
			r.steer = STEER_RIGHT;
			lt = base - off;
			rt = base + off;
		end else if (line_err < -LINE_THRESHOLD) begin
			r.steer = STEER_LEFT;
			lt = base + off;
			rt = base - off;
		end
		dl = t.lcount - last_lcount;
		dr = t.rcount - last_rcount;
		r.encoder_reset = ($signed(dl) > OVERFLOW_DELTA) || ($signed(dr) > OVERFLOW_DELTA);
		last_lcount = r.encoder_reset ? '0 : t.lcount;
		last_rcount = r.encoder_reset ? '0 : t.rcount;
		el = lt - longint'($signed(dl)) * TICKS_PER_SECOND;
		er = rt - longint'($signed(dr)) * TICKS_PER_SECOND;
		el = el > ERR_HI ? ERR_HI : (el < ERR_LO ? ERR_LO : el);
		er = er > ERR_HI ? ERR_HI : (er < ERR_LO ? ERR_LO : er);
		r.left_duty = wheel_pid(1'b0, el);
		r.right_duty = wheel_pid(1'b1, er);
		return r;
	endfunction

	// sense driver
	always @(negedge clk) begin
		if (arst_n && (!sense.valid || sense_fire)) begin
			if (tick_q.size() != 0 && !idle_now()) begin
				tick_t t;
				t = tick_q.pop_front();
				sense.valid <= 1'b1;
				sense.sensor_1 <= t.line[0];
				sense.sensor_2 <= t.line[1];
				sense.sensor_3 <= t.line[2];
				sense.sensor_4 <= t.line[3];
				sense.sensor_5 <= t.line[4];
				sense.sensor_6 <= t.line[5];
				sense.left_count <= t.lcount;
				sense.right_count <= t.rcount;
			end else begin
				sense.valid <= 1'b0;
			end
		end
	end

	// drive back-pressure
	always @(negedge clk)
		drive.ready <= arst_n && !idle_now();

	// acceptance, prediction and checking
	always @(posedge clk) begin
		tick_t   t;
		result_t want;
		sense_fire <= sense.valid && sense.ready;
		if (sense.valid && sense.ready) begin
			t.line = {sense.sensor_6, sense.sensor_5, sense.sensor_4,
				sense.sensor_3, sense.sensor_2, sense.sensor_1};
			t.lcount = sense.left_count;
			t.rcount = sense.right_count;
			want = drive_predict(t);
			duty_expect_q.push_back(want);
			ticks_in++;
			n_right += (want.steer == STEER_RIGHT);
			n_left += (want.steer == STEER_LEFT);
			n_clear += want.encoder_reset;
			n_zero += (want.left_duty == 0) + (want.right_duty == 0);
			n_full += (want.left_duty == DUTY_FULL) + (want.right_duty == DUTY_FULL);
		end
		if (drive.valid && drive.ready) begin
			if (duty_expect_q.size() == 0) begin
				report_mismatch("drive beat with no tick outstanding");
			end else begin
				want = duty_expect_q.pop_front();
				if (drive.left_duty !== want.left_duty)
					report_mismatch($sformatf("left_duty got %0d want %0d",
						drive.left_duty, want.left_duty));
				if (drive.right_duty !== want.right_duty)
					report_mismatch($sformatf("right_duty got %0d want %0d",
						drive.right_duty, want.right_duty));
				if (drive.encoder_reset !== want.encoder_reset)
					report_mismatch($sformatf("encoder_reset got %b want %b",
						drive.encoder_reset, want.encoder_reset));
				if (drive.steer_state !== want.steer)
					report_mismatch($sformatf("steer_state got %0d want %s",
						drive.steer_state, want.steer.name()));
			end
			beats_checked++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d beats still expected",
				cycle_count, duty_expect_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(int'(idx) * 4);
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		reg_mirror[idx] = val;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic program_all(logic [DATA_W-1:0] kpl, kil, kdl, kpr, kir, kdr, base, off);
		reg_write(REG_KP_LEFT, kpl);
		reg_write(REG_KI_LEFT, kil);
		reg_write(REG_KD_LEFT, kdl);
		reg_write(REG_KP_RIGHT, kpr);
		reg_write(REG_KI_RIGHT, kir);
		reg_write(REG_KD_RIGHT, kdr);
		reg_write(REG_BASE_SPEED, base);
		reg_write(REG_STEER_OFFSET, off);
	endtask

	function automatic logic [DATA_W-1:0] rand_gain();
		int                       v;
		logic signed [GAIN_W-1:0] g;
		case ($urandom_range(3))
			0: v = int'($urandom_range(64)) - 32;
			1: v = int'($urandom_range(131072)) - 65536;
			2: v = $urandom();
			default: v = 0;
		endcase
		g = v[GAIN_W-1:0];
		return DATA_W'(g);
	endfunction

	function automatic logic [DATA_W-1:0] rand_speed();
		case ($urandom_range(2))
			0: return DATA_W'($urandom_range(65535));
			1: return DATA_W'($urandom_range(4000, 3000));
			default: return DATA_W'($urandom_range(1000));
		endcase
	endfunction

	function automatic logic [COUNT_W-1:0] rand_delta();
		case ($urandom_range(9))
			0: return $urandom();
			1: return COUNT_W'(OVERFLOW_DELTA - 1 + int'($urandom_range(2)));
			2: return COUNT_W'(-int'($urandom_range(100000)));
			default: return COUNT_W'($urandom_range(80)) - 32'd5;
		endcase
	endfunction

	function automatic line_t lay(int s1, int s2, int s3, int s4, int s5, int s6);
		return {SENSOR_W'(s6), SENSOR_W'(s5), SENSOR_W'(s4),
			SENSOR_W'(s3), SENSOR_W'(s2), SENSOR_W'(s1)};
	endfunction

	task automatic queue_tick_abs(line_t l, logic [COUNT_W-1:0] lc, logic [COUNT_W-1:0] rc);
		tick_q.push_back('{line: l, lcount: lc, rcount: rc});
		if ($signed(lc - enc_last_l) > OVERFLOW_DELTA
				|| $signed(rc - enc_last_r) > OVERFLOW_DELTA) begin
			enc_last_l = '0;
			enc_last_r = '0;
		end else begin
			enc_last_l = lc;
			enc_last_r = rc;
		end
	endtask

	task automatic queue_tick_delta(line_t l, logic [COUNT_W-1:0] dl, logic [COUNT_W-1:0] dr);
		queue_tick_abs(l, enc_last_l + dl, enc_last_r + dr);
	endtask

	task automatic queue_random_tick();
		line_t l;
		int    v;
		case ($urandom_range(3))
			0: l = line_t'({$urandom(), $urandom(), $urandom()});
			1: begin
				for (int i = 0; i < 6; i++)
					l[i] = SENSOR_W'($urandom_range(300));
				l[$urandom_range(5)] = SENSOR_W'($urandom_range(4095, 2000));
			end
			2: begin
				// hovers around the steering threshold on either side
				l = '0;
				v = $urandom_range(684, 680);
				if ($urandom_range(1))
					l[0] = SENSOR_W'(v);
				else
					l[5] = SENSOR_W'(v);
				l[2] = SENSOR_W'($urandom_range(3));
			end
			default: begin
				v = $urandom_range(4095);
				l = lay(v, v, v, v, v, v);
			end
		endcase
		queue_tick_delta(l, rand_delta(), rand_delta());
	endtask

	task automatic drain();
		while (tick_q.size() != 0 || sense.valid || duty_expect_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		sense.valid = 1'b0;
		sense.sensor_1 = '0;
		sense.sensor_2 = '0;
		sense.sensor_3 = '0;
		sense.sensor_4 = '0;
		sense.sensor_5 = '0;
		sense.sensor_6 = '0;
		sense.left_count = '0;
		sense.right_count = '0;
		drive.ready = 1'b0;
		reg_mirror[REG_KP_LEFT] = DATA_W'(KP_RESET);
		reg_mirror[REG_KI_LEFT] = DATA_W'(KI_RESET);
		reg_mirror[REG_KD_LEFT] = DATA_W'(KD_RESET);
		reg_mirror[REG_KP_RIGHT] = DATA_W'(KP_RESET);
		reg_mirror[REG_KI_RIGHT] = DATA_W'(KI_RESET);
		reg_mirror[REG_KD_RIGHT] = DATA_W'(KD_RESET);
		reg_mirror[REG_BASE_SPEED] = DATA_W'(BASE_RESET);
		reg_mirror[REG_STEER_OFFSET] = DATA_W'(OFFSET_RESET);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset gains: line extremes, threshold edges, count boundaries
		queue_tick_abs(lay(0, 0, 0, 0, 0, 0), '0, '0);
		queue_tick_delta(lay(4095, 4095, 4095, 4095, 4095, 4095), 35, 35);
		queue_tick_delta(lay(4095, 4095, 4095, 0, 0, 0), 35, 35);
		queue_tick_delta(lay(0, 0, 0, 4095, 4095, 4095), 35, 35);
		queue_tick_delta(lay(682, 0, 2, 0, 0, 0), 30, 40);
		queue_tick_delta(lay(683, 0, 0, 0, 0, 0), 30, 40);
		queue_tick_delta(lay(0, 0, 0, 2, 0, 682), 40, 30);
		queue_tick_delta(lay(0, 0, 0, 0, 0, 683), 40, 30);
		queue_tick_delta(lay(100, 100, 100, 100, 100, 100), OVERFLOW_DELTA, 0);
		queue_tick_delta(lay(100, 100, 100, 100, 100, 100), OVERFLOW_DELTA + 1, 35);
		queue_tick_delta(lay(100, 100, 100, 100, 100, 100), 0, OVERFLOW_DELTA + 1);
		// most negative delta, then both directions across the signed wrap
		queue_tick_abs(lay(0, 0, 0, 0, 0, 0), 32'h8000_0000, 32'h8000_0000);
		queue_tick_abs(lay(0, 0, 0, 0, 0, 0), 32'h7fff_ffff, 32'h7fff_ffff);
		queue_tick_abs(lay(0, 0, 0, 0, 0, 0), 32'h8000_0000, 32'h8000_0000);
		queue_tick_delta(lay(4095, 0, 0, 0, 0, 4095), 32'h7fff_ffff, 32'h7fff_ffff);
		drain();

		program_all(32'h007f_ffff, 32'h007f_ffff, 32'h007f_ffff,
			32'h007f_ffff, 32'h007f_ffff, 32'h007f_ffff, 32'h0000_ffff, 32'h0000_ffff);
		queue_tick_delta(lay(4095, 4095, 4095, 0, 0, 0), 10, 10);
		queue_tick_delta(lay(0, 0, 0, 4095, 4095, 4095), 10, 10);
		queue_tick_delta(lay(0, 0, 0, 0, 0, 0), 32'h8000_0000, 32'h7fff_ffff);
		queue_tick_delta(lay(0, 0, 0, 0, 0, 0), 0, 0);
		drain();

		program_all(32'hff80_0000, 32'hff80_0000, 32'hff80_0000,
			32'hff80_0000, 32'hff80_0000, 32'hff80_0000, 32'h0000_0000, 32'h0000_ffff);
		queue_tick_delta(lay(4095, 4095, 4095, 0, 0, 0), 0, 0);
		queue_tick_delta(lay(0, 0, 0, 4095, 4095, 4095), 0, 0);
		queue_tick_delta(lay(0, 0, 0, 0, 0, 0), 32'h8000_0000, 32'h7fff_ffff);
		queue_tick_delta(lay(0, 0, 0, 0, 0, 0), 50, 50);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			calm = (ph == 3);
			program_all(rand_gain(), rand_gain(), rand_gain(),
				rand_gain(), rand_gain(), rand_gain(), rand_speed(), rand_speed());
			repeat (BEATS_PER_PHASE) queue_random_tick();
			drain();
		end

		repeat (LANE_LAT * 4) @(posedge clk);
		if (duty_expect_q.size() != 0)
			report_mismatch($sformatf("%0d drive beats never arrived", duty_expect_q.size()));
		$display("Run: %0d ticks in, %0d drive beats checked, %0d mismatches",
			ticks_in, beats_checked, err_count);
		$display("Seen: steer right %0d, left %0d, encoder clears %0d, duty 0 %0d, full %0d",
			n_right, n_left, n_clear, n_zero, n_full);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
